[rtl/cgpd_pkg.sv]
// ----------------------------------------------------------------------------
// cgpd_pkg
// Shared constants, types and helpers for the coded genotype AND/popcount
// dot unit.
// ----------------------------------------------------------------------------
package cgpd_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned TOTAL_W     = 40;
  localparam int unsigned LANE_SUM_W  = 16;
  localparam int unsigned REPEAT      = 10;
  localparam int unsigned GROUP_ITEMS = 2 * REPEAT;
  localparam int unsigned COUNT_W     = $clog2(GROUP_ITEMS + 1);

  localparam logic [WORD_W-1:0] M1 = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] M2 = 64'h3333_3333_3333_3333;
  localparam logic [WORD_W-1:0] M4 = 64'h0f0f_0f0f_0f0f_0f0f;
  localparam logic [WORD_W-1:0] M8 = 64'h00ff_00ff_00ff_00ff;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [LANE_SUM_W-1:0] lane_sum_t;
  typedef logic [TOTAL_W-1:0]    total_t;

  // Control that travels alongside each pipeline stage.
  typedef struct packed {
    logic valid;
    logic eor;
    logic fold;
  } stage_ctl_t;

  // Sum of adjacent 2-bit fields into 4-bit fields.
  function automatic word_t pair_sum(input word_t v);
    pair_sum = (v & M2) + ((v >> 2) & M2);
  endfunction

  // Sum of adjacent bytes into 16-bit fields.
  function automatic word_t byte_fold(input word_t v);
    byte_fold = (v & M8) + ((v >> 8) & M8);
  endfunction

endpackage

[rtl/cgpd_word_reduce.sv]
// ----------------------------------------------------------------------------
// cgpd_word_reduce
// ANDs the word pairs of one lane and reduces them to per-byte counts,
// registered for the accumulator stage.
// ----------------------------------------------------------------------------
module cgpd_word_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  cgpd_pkg::stage_ctl_t ctl_i,
  input  cgpd_pkg::word_t     a0_i,
  input  cgpd_pkg::word_t     a1_i,
  input  cgpd_pkg::word_t     a2_i,
  input  cgpd_pkg::word_t     b0_i,
  input  cgpd_pkg::word_t     b1_i,
  input  cgpd_pkg::word_t     b2_i,
  output cgpd_pkg::stage_ctl_t ctl_o,
  output cgpd_pkg::word_t     byte_sum_o
);

  cgpd_pkg::word_t      x, h1, h2, c1, c2, c;
  cgpd_pkg::word_t      byte_sum_nxt, byte_sum_r;
  cgpd_pkg::stage_ctl_t ctl_r;

  always_comb begin
    x  = a0_i & b0_i;
    h2 = (x >> 1) & cgpd_pkg::M1;
    h1 = (x & cgpd_pkg::M1) | h2;
    c1 = (a1_i & b1_i) + h1;
    c2 = (a2_i & b2_i) + h2;
    c  = cgpd_pkg::pair_sum(c1) + cgpd_pkg::pair_sum(c2);
    byte_sum_nxt = (c & cgpd_pkg::M4) + ((c >> 4) & cgpd_pkg::M4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
    if (adv) begin
      byte_sum_r <= byte_sum_nxt;
    end
  end

  assign ctl_o      = ctl_r;
  assign byte_sum_o = byte_sum_r;

endmodule

[rtl/cgpd_lane_accum.sv]
// ----------------------------------------------------------------------------
// cgpd_lane_accum
// Per-lane byte accumulators and the group counter; hands both lanes to the
// fold stage when a group completes or the row pair ends.
// ----------------------------------------------------------------------------
module cgpd_lane_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  cgpd_pkg::stage_ctl_t ctl_i,
  input  cgpd_pkg::word_t      byte_sum_i,
  output cgpd_pkg::stage_ctl_t ctl_o,
  output cgpd_pkg::word_t      fold_acc0_o,
  output cgpd_pkg::word_t      fold_acc1_o
);

  cgpd_pkg::word_t      acc0_r, acc1_r, acc0_nxt, acc1_nxt;
  cgpd_pkg::word_t      fold_acc0_r, fold_acc1_r;
  cgpd_pkg::count_t     count_r, count_nxt;
  cgpd_pkg::stage_ctl_t ctl_r, ctl_nxt;
  logic                 fold;

  always_comb begin
    acc0_nxt  = acc0_r;
    acc1_nxt  = acc1_r;
    if (count_r[0]) begin
      acc1_nxt = acc1_r + byte_sum_i;
    end else begin
      acc0_nxt = acc0_r + byte_sum_i;
    end
    count_nxt = count_r + cgpd_pkg::count_t'(1);
    fold      = ctl_i.eor ||
                (count_nxt >= cgpd_pkg::count_t'(cgpd_pkg::GROUP_ITEMS));
    ctl_nxt       = ctl_i;
    ctl_nxt.fold  = ctl_i.valid && fold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc0_r  <= '0;
      acc1_r  <= '0;
      count_r <= '0;
      ctl_r   <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
      if (ctl_i.valid) begin
        if (fold) begin
          acc0_r  <= '0;
          acc1_r  <= '0;
          count_r <= '0;
        end else begin
          acc0_r  <= acc0_nxt;
          acc1_r  <= acc1_nxt;
          count_r <= count_nxt;
        end
      end
    end
    if (adv) begin
      fold_acc0_r <= acc0_nxt;
      fold_acc1_r <= acc1_nxt;
    end
  end

  assign ctl_o       = ctl_r;
  assign fold_acc0_o = fold_acc0_r;
  assign fold_acc1_o = fold_acc1_r;

endmodule

[rtl/cgpd_fold_total.sv]
// ----------------------------------------------------------------------------
// cgpd_fold_total
// Folds both lane accumulators into a 16-bit group sum, keeps the saturating
// running total and holds the result register.
// ----------------------------------------------------------------------------
module cgpd_fold_total (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  cgpd_pkg::stage_ctl_t ctl_i,
  input  cgpd_pkg::word_t      acc0_i,
  input  cgpd_pkg::word_t      acc1_i,
  input  logic                 out_stall,
  output logic                 out_valid,
  output cgpd_pkg::total_t     out_pair_total,
  output logic                 block_o
);

  cgpd_pkg::word_t       lane_fold;
  cgpd_pkg::lane_sum_t   add_nxt, add_r;
  cgpd_pkg::stage_ctl_t  ctl_r;
  cgpd_pkg::total_t      total_r, total_sat, out_total_r;
  logic [cgpd_pkg::TOTAL_W:0] total_sum;
  logic                  out_valid_r, out_valid_nxt;

  always_comb begin
    lane_fold = cgpd_pkg::byte_fold(acc0_i) + cgpd_pkg::byte_fold(acc1_i);
    // Sum of the four 16-bit fields, modulo 2^16.
    add_nxt = '0;
    if (ctl_i.fold) begin
      add_nxt = lane_fold[15:0] + lane_fold[31:16] + lane_fold[47:32] + lane_fold[63:48];
    end
    total_sum = {1'b0, total_r} + {{(cgpd_pkg::TOTAL_W + 1 - cgpd_pkg::LANE_SUM_W){1'b0}}, add_r};
    total_sat = total_sum[cgpd_pkg::TOTAL_W] ? cgpd_pkg::TOTAL_MAX
                                             : total_sum[cgpd_pkg::TOTAL_W-1:0];
    // A waiting total stays until taken; a closing beat loads a new one.
    out_valid_nxt = out_valid_r && out_stall;
    if (adv && ctl_r.valid && ctl_r.eor) begin
      out_valid_nxt = 1'b1;
    end
  end

  // A finished total that cannot leave holds the whole pipeline.
  assign block_o = out_valid_r && out_stall && ctl_r.valid && ctl_r.eor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        ctl_r <= ctl_i;
        if (ctl_r.valid) begin
          if (ctl_r.eor) begin
            total_r <= '0;
          end else begin
            total_r <= total_sat;
          end
        end
      end
    end
    if (adv) begin
      add_r <= add_nxt;
      if (ctl_r.valid && ctl_r.eor) begin
        out_total_r <= total_sat;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pair_total = out_total_r;

endmodule

[rtl/coded_genotype_and_popcount_dot_unit.sv]
// ----------------------------------------------------------------------------
// coded_genotype_and_popcount_dot_unit
// AND-and-popcount dot product of two coded genotype rows, one lane per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one 64-bit lane of three coded words of row A and
// of row B; beats alternate lane 0 and lane 1, starting with lane 0 after
// reset and after each emitted total. The beat flagged with in_end_of_rows
// closes the row pair and produces exactly one output beat carrying the
// saturated 40-bit pair total; all other beats produce no output.
// Throughput is one beat per cycle while in_stall is low. The pipeline has
// an input register, a word-reduce register, the lane accumulator with its
// fold capture, the group-fold register and the result register, which a
// closing input beat passes in that order before its total sets out_valid.
// A synchronous active-low reset clears all accumulators, the group counter,
// the running total and every valid flag.
// When the receiver stalls, a waiting total holds in the result register
// while further input beats keep flowing; only when a second total reaches
// the group-fold register does the pipeline freeze, and in_stall then follows
// out_stall until the waiting total is taken.
// ----------------------------------------------------------------------------
module coded_genotype_and_popcount_dot_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [63:0]             in_row_a_word0,
  input  logic [63:0]             in_row_a_word1,
  input  logic [63:0]             in_row_a_word2,
  input  logic [63:0]             in_row_b_word0,
  input  logic [63:0]             in_row_b_word1,
  input  logic [63:0]             in_row_b_word2,
  input  logic                    in_end_of_rows,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [39:0]             out_pair_total
);

  // Global advance: every stage moves together unless a second total is
  // stuck behind one that the receiver has not taken.
  logic                 block;
  logic                 adv;

  cgpd_pkg::stage_ctl_t in_ctl_r, red_ctl, acc_ctl;
  cgpd_pkg::word_t      a0_r, a1_r, a2_r, b0_r, b1_r, b2_r;
  cgpd_pkg::word_t      byte_sum, fold_acc0, fold_acc1;

  assign adv      = !block;
  assign in_stall = block;

  // Input register. The fold bit is set later, in the accumulator stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
    end else if (adv) begin
      in_ctl_r.valid <= in_valid;
      in_ctl_r.eor   <= in_valid && in_end_of_rows;
      in_ctl_r.fold  <= 1'b0;
    end
    if (adv && in_valid) begin
      a0_r <= in_row_a_word0;
      a1_r <= in_row_a_word1;
      a2_r <= in_row_a_word2;
      b0_r <= in_row_b_word0;
      b1_r <= in_row_b_word1;
      b2_r <= in_row_b_word2;
    end
  end

  cgpd_word_reduce u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .ctl_i      (in_ctl_r),
    .a0_i       (a0_r),
    .a1_i       (a1_r),
    .a2_i       (a2_r),
    .b0_i       (b0_r),
    .b1_i       (b1_r),
    .b2_i       (b2_r),
    .ctl_o      (red_ctl),
    .byte_sum_o (byte_sum)
  );

  cgpd_lane_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .ctl_i       (red_ctl),
    .byte_sum_i  (byte_sum),
    .ctl_o       (acc_ctl),
    .fold_acc0_o (fold_acc0),
    .fold_acc1_o (fold_acc1)
  );

  cgpd_fold_total u_total (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .ctl_i          (acc_ctl),
    .acc0_i         (fold_acc0),
    .acc1_i         (fold_acc1),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_pair_total (out_pair_total),
    .block_o        (block)
  );

endmodule
